[design/dmc_pkg.sv]
// Shared types for the direct-mapped write-back cache: controller states, command and status.
`default_nettype none
package dmc_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAG_RD,
    ST_COMPARE,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // capture the input item
    logic clear_step;  // zero one backing word
    logic cnt_clr;     // restart the word counter
    logic judge;       // latch the hit flag
    logic wb_step;     // one step of the victim write-back
    logic fill_step;   // one step of the line fetch
    logic fill_done;   // install tag, valid, clean
    logic access;      // word read or write in the line
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_last;
    logic hit;
    logic victim_dirty;
  } status_t;

endpackage
`default_nettype wire

[design/dmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/dmc_ctrl.sv]
// Controller state machine for the cache: sequences clear, lookup, write-back, fetch and access.
`default_nettype none
module dmc_ctrl
  import dmc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (start) state_nxt = ST_TAG_RD;
      ST_TAG_RD:  state_nxt = ST_COMPARE;
      ST_COMPARE: begin
        priority if (status.hit)          state_nxt = ST_ACCESS;
        else if (status.victim_dirty)     state_nxt = ST_WB;
        else                              state_nxt = ST_FILL;
      end
      ST_WB:      if (status.cnt_last) state_nxt = ST_FILL;
      ST_FILL:    if (status.cnt_last) state_nxt = ST_ACCESS;
      ST_ACCESS:  state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR:   cmd.clear_step = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_TAG_RD:  ;
      ST_COMPARE: begin
        cmd.judge   = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      ST_WB: begin
        cmd.wb_step = 1'b1;
        cmd.cnt_clr = status.cnt_last;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        cmd.fill_done = status.cnt_last;
        cmd.cnt_clr   = status.cnt_last;
      end
      ST_ACCESS:  cmd.access = 1'b1;
      ST_DONE:    out_valid  = 1'b1;
      default:    ;
    endcase
  end

endmodule
`default_nettype wire

[design/dmc_dp.sv]
// Cache datapath: item registers, tag/valid/dirty state, line data RAM and backing memory.
`default_nettype none
module dmc_dp
  import dmc_pkg::*;
#(
  parameter int LINE_COUNT     = 16,
  parameter int WORDS_PER_LINE = 4,
  parameter int ADDRESS_BITS   = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  input  wire logic                    in_op,
  input  wire logic [ADDRESS_BITS-1:0] in_address,
  input  wire logic [31:0]             in_write_data,
  output status_t                      status,
  output logic                         out_hit,
  output logic [31:0]                  out_read_word
);

  localparam int WA         = ADDRESS_BITS - 2;
  localparam int WBITS      = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int IB         = $clog2(LINE_COUNT);
  localparam int TB_RAW     = WA - $clog2(WORDS_PER_LINE) - IB;
  localparam int TB         = (TB_RAW > 0) ? TB_RAW : 1;
  localparam int CB         = $clog2(WORDS_PER_LINE + 1);
  localparam int DEPTH_DATA = LINE_COUNT * WORDS_PER_LINE;
  localparam int DA         = $clog2(DEPTH_DATA);
  localparam int MEM_WORDS  = 1 << WA;
  localparam int BLOCK_SPAN = LINE_COUNT * WORDS_PER_LINE;

  logic            op_r;
  logic [31:0]     wdata_r;
  logic [WBITS-1:0] word_r;
  logic [IB-1:0]   idx_r;
  logic [TB-1:0]   tag_r;
  logic            hit_r;
  logic [CB-1:0]   cnt_r;
  logic [WA-1:0]   clr_cnt_r;
  logic [LINE_COUNT-1:0] valid_r;
  logic [LINE_COUNT-1:0] dirty_r;

  logic [WA-1:0]   wa_in;
  logic [TB-1:0]   tag_q;
  logic [31:0]     data_rdata;
  logic [31:0]     mem_rdata;
  logic [WBITS-1:0] word_cur;
  logic [WBITS-1:0] word_prev;
  logic [DA-1:0]   line_base;
  logic [WA-1:0]   victim_base;
  logic [WA-1:0]   block_base;

  logic            data_we;
  logic [DA-1:0]   data_waddr;
  logic [31:0]     data_wdata;
  logic [DA-1:0]   data_raddr;
  logic            mem_we;
  logic [WA-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic [WA-1:0]   mem_raddr;

  assign wa_in = in_address[ADDRESS_BITS-1:2];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      wdata_r <= in_write_data;
      word_r  <= WBITS'(wa_in % WORDS_PER_LINE);
      idx_r   <= IB'((wa_in / WORDS_PER_LINE) % LINE_COUNT);
      tag_r   <= TB'(wa_in / BLOCK_SPAN);
    end
    if (cmd.judge) begin
      hit_r <= status.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      clr_cnt_r <= '0;
      valid_r   <= '0;
      dirty_r   <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.wb_step || cmd.fill_step) begin
        cnt_r <= cnt_r + CB'(1);
      end
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + WA'(1);
      end
      if (cmd.fill_done) begin
        valid_r[idx_r] <= 1'b1;
        dirty_r[idx_r] <= 1'b0;
      end else if (cmd.access && op_r) begin
        dirty_r[idx_r] <= 1'b1;
      end
    end
  end

  // word being read this step, and word whose read data arrives this step
  assign word_cur    = WBITS'(cnt_r);
  assign word_prev   = WBITS'(cnt_r - CB'(1));
  assign line_base   = DA'(idx_r) * DA'(WORDS_PER_LINE);
  assign victim_base = WA'(tag_q) * WA'(BLOCK_SPAN) + WA'(idx_r) * WA'(WORDS_PER_LINE);
  assign block_base  = WA'(tag_r) * WA'(BLOCK_SPAN) + WA'(idx_r) * WA'(WORDS_PER_LINE);

  assign status.clr_last     = &clr_cnt_r;
  assign status.cnt_last     = (cnt_r == CB'(WORDS_PER_LINE));
  assign status.hit          = valid_r[idx_r] && (tag_q == tag_r);
  assign status.victim_dirty = valid_r[idx_r] && dirty_r[idx_r];

  always_comb begin
    data_we    = (cmd.fill_step && (cnt_r != '0)) || (cmd.access && op_r);
    data_waddr = cmd.access ? line_base + DA'(word_r) : line_base + DA'(word_prev);
    data_wdata = cmd.access ? wdata_r : mem_rdata;
    data_raddr = cmd.wb_step ? line_base + DA'(word_cur) : line_base + DA'(word_r);
    mem_we     = cmd.clear_step || (cmd.wb_step && (cnt_r != '0));
    mem_waddr  = cmd.clear_step ? clr_cnt_r : victim_base + WA'(word_prev);
    mem_wdata  = cmd.clear_step ? 32'd0 : data_rdata;
    mem_raddr  = block_base + WA'(word_cur);
  end

  dmc_ram #(.WIDTH(TB), .DEPTH(LINE_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.fill_done),
    .waddr (idx_r),
    .wdata (tag_r),
    .raddr (idx_r),
    .rdata (tag_q)
  );

  dmc_ram #(.WIDTH(32), .DEPTH(DEPTH_DATA)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  dmc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_backing_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_hit       = hit_r;
  assign out_read_word = op_r ? wdata_r : data_rdata;

endmodule
`default_nettype wire

[design/direct_mapped_writeback_cache_core.sv]
// Top level of the direct-mapped write-back, write-allocate cache with its backing memory.
// An item passes tag read and compare, then on a miss a write-back of a dirty victim and a line
// fetch, then access and the result strobe; the word-wide backing memory port moves one word
// a cycle during write-back and fetch. One item at a time, and the receiver cannot hold
// results off: the next item can be taken the cycle after the strobe.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 2^(ADDRESS_BITS-2) words
// of the backing memory (262144 at defaults), one word a cycle, with busy held high.
`default_nettype none
module direct_mapped_writeback_cache_core
  import dmc_pkg::*;
#(
  parameter int LINE_COUNT     = 16,
  parameter int WORDS_PER_LINE = 4,
  parameter int ADDRESS_BITS   = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_op,
  input  wire logic [ADDRESS_BITS-1:0] in_address,
  input  wire logic [31:0]             in_write_data,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [31:0]                  out_read_word
);

  // Controller issues commands; datapath answers with lookup and counter status.
  cmd_t    cmd;
  status_t status;

  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath holds the item, line state, line data RAM and the backing memory.
  dmc_dp #(
    .LINE_COUNT     (LINE_COUNT),
    .WORDS_PER_LINE (WORDS_PER_LINE),
    .ADDRESS_BITS   (ADDRESS_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_op         (in_op),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .status        (status),
    .out_hit       (out_hit),
    .out_read_word (out_read_word)
  );

  // A result only appears while the item is still in flight.
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an item");

  // The strobe lasts one cycle and the block is free straight after.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not single or block stays busy");

  // An accepted item keeps the block busy and cannot produce a result the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not start work");

endmodule
`default_nettype wire
